>>> rtl/sensor_frame_crc_check_unpack_unit_macros.svh
// Assertion macros used by the frame tracker of the sensor frame checker RTL.
`ifndef SENSOR_FRAME_CRC_CHECK_UNPACK_UNIT_MACROS_SVH
`define SENSOR_FRAME_CRC_CHECK_UNPACK_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SFCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SFCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sfcc_pkg.sv
// Package: constants, types and the CRC-8 update function of the frame checker.
`default_nettype none

package sfcc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned FieldW = 20;
  localparam int unsigned PosW   = 3;
  localparam int unsigned PayW   = 40;

  // Byte position codes
  localparam logic [PosW-1:0] POS_FIRST = 3'd1;
  localparam logic [PosW-1:0] POS_CHECK = 3'd6;
  localparam logic [PosW-1:0] POS_IDLE  = 3'd7;

  localparam logic [ByteW-1:0] CRC_INIT = 8'hFF;
  localparam logic [ByteW-1:0] CRC_POLY = 8'h31;

  // Unpacked result of one frame
  typedef struct packed {
    logic              crc_ok;
    logic [FieldW-1:0] humidity_raw;
    logic [FieldW-1:0] temperature_raw;
  } sfcc_result_t;

  // Control from the frame tracker to the top level
  typedef struct packed {
    logic emit;        // accepted transaction completes a frame
    logic check_next;  // next byte is the CRC byte
  } sfcc_trk_ctrl_t;

  // CRC-8, MSB first, one byte
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sfcc_byte_if.sv
// Interfaces: received byte channel and frame result channel.
`default_nettype none

interface sfcc_byte_if;
  logic                           valid;
  logic                           ready;
  logic [sfcc_pkg::ByteW-1:0]     rx_byte;
  logic                           frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcc_result_if;
  logic                           valid;
  logic                           ready;
  logic                           crc_ok;
  logic [sfcc_pkg::FieldW-1:0]    humidity_raw;
  logic [sfcc_pkg::FieldW-1:0]    temperature_raw;

  modport source (output valid, output crc_ok, output humidity_raw,
                  output temperature_raw, input ready);
  modport sink   (input valid, input crc_ok, input humidity_raw,
                  input temperature_raw, output ready);
endinterface

`default_nettype wire

>>> rtl/sfcc_frame_tracker.sv
// Frame tracker: byte position, running CRC and payload shift register.
`default_nettype none
`include "sensor_frame_crc_check_unpack_unit_macros.svh"

module sfcc_frame_tracker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         fire_i,
  input  wire logic [sfcc_pkg::ByteW-1:0]   rx_byte_i,
  input  wire logic                         frame_start_i,
  output sfcc_pkg::sfcc_trk_ctrl_t          ctrl_o,
  output sfcc_pkg::sfcc_result_t            result_o
);

  logic [sfcc_pkg::PosW-1:0]  pos_q, pos_d;
  logic [sfcc_pkg::ByteW-1:0] crc_q, crc_d;
  logic [sfcc_pkg::PayW-1:0]  pay_q, pay_d;
  logic                       in_frame;
  logic                       emit;

  // Bytes 1 to 5 are collected; position 0 is never entered
  assign in_frame = (pos_q != sfcc_pkg::POS_IDLE) && (pos_q != '0) &&
                    (pos_q != sfcc_pkg::POS_CHECK);
  assign emit     = fire_i && !frame_start_i && (pos_q == sfcc_pkg::POS_CHECK);

  // Advance position, CRC and payload
  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    pay_d = pay_q;
    if (fire_i) begin
      if (frame_start_i) begin
        pos_d = sfcc_pkg::POS_FIRST;
        crc_d = sfcc_pkg::crc8_update(sfcc_pkg::CRC_INIT, rx_byte_i);
        pay_d = '0;
      end else if (in_frame) begin
        pos_d = pos_q + 3'd1;
        crc_d = sfcc_pkg::crc8_update(crc_q, rx_byte_i);
        pay_d = {pay_q[sfcc_pkg::PayW-sfcc_pkg::ByteW-1:0], rx_byte_i};
      end else if (pos_q == sfcc_pkg::POS_CHECK) begin
        pos_d = sfcc_pkg::POS_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= sfcc_pkg::POS_IDLE;
      crc_q <= sfcc_pkg::CRC_INIT;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  // Payload is only read after a start has cleared it
  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  // Unpack and check the finished frame
  assign result_o.crc_ok          = (crc_q == rx_byte_i);
  assign result_o.humidity_raw    = pay_q[sfcc_pkg::PayW-1:sfcc_pkg::FieldW];
  assign result_o.temperature_raw = pay_q[sfcc_pkg::FieldW-1:0];

  assign ctrl_o.emit       = emit;
  assign ctrl_o.check_next = (pos_q == sfcc_pkg::POS_CHECK);

  `SFCC_ASSERT_NEXT(a_start_restarts, clk_i, rst_ni, fire_i && frame_start_i,
                    pos_q == sfcc_pkg::POS_FIRST, "start byte did not restart frame")
  `SFCC_ASSERT_NEXT(a_emit_goes_idle, clk_i, rst_ni, emit,
                    pos_q == sfcc_pkg::POS_IDLE, "frame end did not return to idle")
  `SFCC_ASSERT_NEXT(a_idle_ignores, clk_i, rst_ni,
                    fire_i && !frame_start_i && (pos_q == sfcc_pkg::POS_IDLE),
                    (pos_q == sfcc_pkg::POS_IDLE) && $stable(crc_q),
                    "idle byte changed frame state")

endmodule

`default_nettype wire

>>> rtl/sfcc_result_reg.sv
// Result register: holds one frame result until the receiver takes it.
`default_nettype none

module sfcc_result_reg (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire sfcc_pkg::sfcc_result_t  data_i,
  sfcc_result_if.source                res_o
);

  logic                   valid_q, valid_d;
  sfcc_pkg::sfcc_result_t data_q;

  // Load on a new result, drop once taken
  assign valid_d = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign res_o.valid           = valid_q;
  assign res_o.crc_ok          = data_q.crc_ok;
  assign res_o.humidity_raw    = data_q.humidity_raw;
  assign res_o.temperature_raw = data_q.temperature_raw;

endmodule

`default_nettype wire

>>> rtl/sensor_frame_crc_check_unpack_unit.sv
// Top level: sensor reply frame CRC-8 checker and humidity/temperature unpacker.
//
// Usage: byte_i carries one reply byte per transaction, frame_start marking byte 0.
// Bytes 0..5 run through CRC-8 (poly 0x31, init 0xFF, MSB first); bytes 1..5
// are kept as payload. Byte 6 yields one transaction on result_o with crc_ok,
// the 20-bit humidity and the 20-bit temperature. Other bytes yield nothing.
// A frame_start byte always restarts the frame; bytes while idle are dropped.
// Throughput: one byte per cycle while byte_i.ready is high; the CRC update is one unrolled byte step
// between the frame state registers.
// Output: result_o.valid is registered and rises in the cycle after byte 6 is accepted.
// Stall: the result register holds while result_o.ready is low. Bytes 0..5
// keep flowing; byte_i.ready drops only when the next byte is the CRC byte
// and the previous result is still waiting.
// Reset: rst_ni clears the frame state to idle and empties the result register.
`default_nettype none

module sensor_frame_crc_check_unpack_unit (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sfcc_byte_if.sink     byte_i,
  sfcc_result_if.source result_o
);

  sfcc_pkg::sfcc_trk_ctrl_t trk_ctrl;
  sfcc_pkg::sfcc_result_t   trk_result;
  logic                     in_fire;
  logic                     out_blocked;

  // Hold off only the CRC byte while a result is stuck
  assign out_blocked  = result_o.valid && !result_o.ready;
  assign byte_i.ready = !(trk_ctrl.check_next && out_blocked);
  assign in_fire      = byte_i.valid && byte_i.ready;

  sfcc_frame_tracker u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .rx_byte_i     (byte_i.rx_byte),
    .frame_start_i (byte_i.frame_start),
    .ctrl_o        (trk_ctrl),
    .result_o      (trk_result)
  );

  sfcc_result_reg u_result (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (trk_ctrl.emit),
    .data_i (trk_result),
    .res_o  (result_o)
  );

endmodule

`default_nettype wire
